@@ design/s3fifo_cache_replacement_unit_assert.svh @@
// ----------------------------------------------------------------------------
// S3-FIFO replacement unit assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef S3FIFO_CACHE_REPLACEMENT_UNIT_ASSERT_SVH
`define S3FIFO_CACHE_REPLACEMENT_UNIT_ASSERT_SVH

// Same-cycle implication.
`define S3FCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define S3FCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/s3fcr_pkg.sv @@
// ----------------------------------------------------------------------------
// S3-FIFO replacement unit package
// Shared widths, register indexes and the cell chain command type.
// ----------------------------------------------------------------------------
`default_nettype none

package s3fcr_pkg;

  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned FREQ_W    = 2;
  localparam int unsigned CAP_W     = 24;
  localparam int unsigned THR_W     = 3;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned EV_W      = 8;
  localparam int unsigned IN_KEY_W  = 32;
  localparam int unsigned S_DATA_W  = 48;
  localparam int unsigned M_DATA_W  = 16;
  localparam longint unsigned MAX_SIZE = 64'd65535;

  localparam int unsigned SMALL_SLOTS_DEF = 64;
  localparam int unsigned MAIN_SLOTS_DEF  = 512;
  localparam int unsigned GHOST_SLOTS_DEF = 512;
  localparam int unsigned KEY_BITS_DEF    = 32;

  localparam logic [CAP_W-1:0] SMALL_CAP_RST = 24'd100;
  localparam logic [CAP_W-1:0] MAIN_CAP_RST  = 24'd900;
  localparam logic [CAP_W-1:0] GHOST_CAP_RST = 24'd900;
  localparam logic [THR_W-1:0] THR_RST       = 3'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SMALL_CAP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_CAP  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GHOST_CAP = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd3;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_PUSH    = 3'd1,
    OP_POP     = 3'd2,
    OP_ROTATE  = 3'd3,
    OP_BUMP    = 3'd4,
    OP_REMOVE  = 3'd5,
    OP_COMPACT = 3'd6
  } chain_op_e;

  typedef struct packed {
    chain_op_e op;
    logic      cmp_en;
  } chain_ctl_t;

endpackage

`default_nettype wire

@@ design/s3fcr_cell.sv @@
// ----------------------------------------------------------------------------
// S3-FIFO queue cell
// One queue entry; shifts toward the head and compares its key in place.
// ----------------------------------------------------------------------------
`default_nettype none

module s3fcr_cell #(
  parameter  int unsigned KEY_W = s3fcr_pkg::KEY_BITS_DEF,
  localparam int unsigned ENT_W = KEY_W + s3fcr_pkg::SIZE_W + s3fcr_pkg::FREQ_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  s3fcr_pkg::chain_ctl_t  ctl_i,
  input  logic [KEY_W-1:0]       cmp_key_i,
  input  logic [ENT_W-1:0]       push_ent_i,
  input  logic [ENT_W-1:0]       rot_ent_i,
  input  logic                   prev_valid_i,
  input  logic                   nxt_valid_i,
  input  logic [ENT_W-1:0]       nxt_ent_i,
  output logic                   valid_o,
  output logic [ENT_W-1:0]       ent_o,
  output logic                   match_o
);

  logic                           valid_q, valid_d;
  logic [ENT_W-1:0]               ent_q, ent_d;
  logic [s3fcr_pkg::FREQ_W-1:0]   freq;

  assign freq    = ent_q[s3fcr_pkg::FREQ_W-1:0];
  assign match_o = ctl_i.cmp_en & valid_q & (ent_q[ENT_W-1 -: KEY_W] == cmp_key_i);
  assign valid_o = valid_q;
  assign ent_o   = ent_q;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    case (ctl_i.op)
      s3fcr_pkg::OP_BUMP: begin
        if (match_o && (freq != '1)) begin
          ent_d[s3fcr_pkg::FREQ_W-1:0] = freq + 1'b1;
        end
      end
      s3fcr_pkg::OP_REMOVE: begin
        if (match_o) begin
          valid_d = 1'b0;
        end
      end
      s3fcr_pkg::OP_PUSH: begin
        if (!valid_q && prev_valid_i) begin
          ent_d   = push_ent_i;
          valid_d = 1'b1;
        end
      end
      s3fcr_pkg::OP_POP: begin
        ent_d   = nxt_ent_i;
        valid_d = nxt_valid_i;
      end
      s3fcr_pkg::OP_ROTATE: begin
        // the tail cell takes the old head, all others advance
        if (valid_q && !nxt_valid_i) begin
          ent_d = rot_ent_i;
        end else begin
          ent_d   = nxt_ent_i;
          valid_d = nxt_valid_i;
        end
      end
      s3fcr_pkg::OP_COMPACT: begin
        if (!valid_q && nxt_valid_i) begin
          ent_d   = nxt_ent_i;
          valid_d = 1'b1;
        end else if (valid_q && !prev_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

@@ design/s3fcr_chain.sv @@
// ----------------------------------------------------------------------------
// S3-FIFO queue chain
// A row of cells forming one FIFO, head in cell 0, with its entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module s3fcr_chain #(
  parameter  int unsigned SLOTS = s3fcr_pkg::MAIN_SLOTS_DEF,
  parameter  int unsigned KEY_W = s3fcr_pkg::KEY_BITS_DEF,
  localparam int unsigned ENT_W = KEY_W + s3fcr_pkg::SIZE_W + s3fcr_pkg::FREQ_W,
  localparam int unsigned CNT_W = $clog2(SLOTS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  s3fcr_pkg::chain_ctl_t       ctl_i,
  input  logic [KEY_W-1:0]            cmp_key_i,
  input  logic [ENT_W-1:0]            push_ent_i,
  output logic [ENT_W-1:0]            head_ent_o,
  output logic [CNT_W-1:0]            count_o,
  output logic                        hit_o,
  output logic [s3fcr_pkg::SIZE_W-1:0] hit_size_o,
  output logic                        hole_o
);

  localparam int unsigned FW = s3fcr_pkg::FREQ_W;

  logic             valid [SLOTS];
  logic [ENT_W-1:0] ent   [SLOTS];
  logic             match [SLOTS];
  logic [ENT_W-1:0] rot_ent;
  logic [CNT_W-1:0] count_q, count_d;

  // old head re-enters at the tail with its counter lowered
  assign rot_ent = {ent[0][ENT_W-1:FW], ent[0][FW-1:0] - 1'b1};

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic             prev_v;
    logic             nxt_v;
    logic [ENT_W-1:0] nxt_e;
    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = valid[i-1];
    end
    if (i == SLOTS - 1) begin : g_last
      assign nxt_v = 1'b0;
      assign nxt_e = '0;
    end else begin : g_inner
      assign nxt_v = valid[i+1];
      assign nxt_e = ent[i+1];
    end
    s3fcr_cell #(.KEY_W(KEY_W)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .cmp_key_i   (cmp_key_i),
      .push_ent_i  (push_ent_i),
      .rot_ent_i   (rot_ent),
      .prev_valid_i(prev_v),
      .nxt_valid_i (nxt_v),
      .nxt_ent_i   (nxt_e),
      .valid_o     (valid[i]),
      .ent_o       (ent[i]),
      .match_o     (match[i])
    );
  end

  always_comb begin
    hit_o      = 1'b0;
    hit_size_o = '0;
    hole_o     = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_o      = hit_o | match[i];
      hit_size_o = hit_size_o | ({s3fcr_pkg::SIZE_W{match[i]}} & ent[i][FW +: s3fcr_pkg::SIZE_W]);
    end
    for (int i = 0; i + 1 < SLOTS; i++) begin
      hole_o = hole_o | (!valid[i] & valid[i+1]);
    end
  end

  always_comb begin
    count_d = count_q;
    case (ctl_i.op)
      s3fcr_pkg::OP_PUSH:   count_d = count_q + 1'b1;
      s3fcr_pkg::OP_POP:    count_d = count_q - 1'b1;
      s3fcr_pkg::OP_REMOVE: if (hit_o) count_d = count_q - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_ent_o = ent[0];
  assign count_o    = count_q;

endmodule

`default_nettype wire

@@ design/s3fifo_cache_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// S3-FIFO cache replacement unit
// Tracks small, main and ghost FIFOs and reports hit, admission and evictions.
// ----------------------------------------------------------------------------
// One access at a time. The small, main and ghost queues are each a row of
// cells that compare their keys in place and shift toward the head, so a
// lookup is done in the S_LOOK state. On a hit, or for an object too large to
// admit, S_DECIDE goes on to S_DONE, which registers the result. A miss that
// admits without any eviction passes S_EVLOOP and S_ADMIT. Each main eviction
// passes S_EVMAIN, which rotates each main head with a nonzero counter back to
// the tail with a lowered counter before it pops. Each small eviction pass
// pops the small head in S_EVSMALL and sends each entry promoted to main
// through S_PROMOTE, until one entry is dropped toward the ghost through
// S_GPUT or small runs empty. Inserting that key in the ghost goes through
// S_GEVICT, which first pops ghost entries to make room. A promotion into a
// full main queue first pops main through S_EVMAIN, with its rotations.
// Removing a key from the ghost leaves a hole that closes one cell per cycle
// in S_COMPACT. The result waits in an output register; the next access is
// taken once the sequencer is idle again, even while that result still waits.
// Configuration writes are taken in every cycle.
`default_nettype none
`include "s3fifo_cache_replacement_unit_assert.svh"

module s3fifo_cache_replacement_unit #(
  parameter int unsigned SMALL_SLOTS = s3fcr_pkg::SMALL_SLOTS_DEF,
  parameter int unsigned MAIN_SLOTS  = s3fcr_pkg::MAIN_SLOTS_DEF,
  parameter int unsigned GHOST_SLOTS = s3fcr_pkg::GHOST_SLOTS_DEF,
  parameter int unsigned KEY_BITS    = s3fcr_pkg::KEY_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // s_tdata_i: object_key [31:0], object_size [47:32]
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [s3fcr_pkg::S_DATA_W-1:0]    s_tdata_i,
  // m_tdata_o: hit [0], ghost_hit [1], admitted_to [3:2], evicted_count [11:4]
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [s3fcr_pkg::M_DATA_W-1:0]    m_tdata_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [s3fcr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [s3fcr_pkg::CAP_W-1:0]       cfg_data_i
);

  localparam int unsigned SZ_W  = s3fcr_pkg::SIZE_W;
  localparam int unsigned FW    = s3fcr_pkg::FREQ_W;
  localparam int unsigned CW    = s3fcr_pkg::CAP_W;
  localparam int unsigned ENT_W = KEY_BITS + SZ_W + FW;
  localparam int unsigned SC_W  = $clog2(SMALL_SLOTS + 1);
  localparam int unsigned MC_W  = $clog2(MAIN_SLOTS + 1);
  localparam int unsigned GC_W  = $clog2(GHOST_SLOTS + 1);
  localparam int unsigned SU_W  = $clog2(longint'(SMALL_SLOTS) * s3fcr_pkg::MAX_SIZE + 1);
  localparam int unsigned MU_W  = $clog2(longint'(MAIN_SLOTS) * s3fcr_pkg::MAX_SIZE + 1);
  localparam int unsigned GU_W  = $clog2(longint'(GHOST_SLOTS) * s3fcr_pkg::MAX_SIZE + 1);
  localparam int unsigned WA    = (SU_W > MU_W) ? SU_W : MU_W;
  localparam int unsigned CMP_W = ((WA > CW + 1) ? WA : CW + 1) + 2;
  localparam int unsigned GCM_W = ((GU_W > CW) ? GU_W : CW) + 1;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_LOOK    = 12'b0000_0000_0010,
    S_COMPACT = 12'b0000_0000_0100,
    S_DECIDE  = 12'b0000_0000_1000,
    S_EVLOOP  = 12'b0000_0001_0000,
    S_EVMAIN  = 12'b0000_0010_0000,
    S_EVSMALL = 12'b0000_0100_0000,
    S_PROMOTE = 12'b0000_1000_0000,
    S_GPUT    = 12'b0001_0000_0000,
    S_GEVICT  = 12'b0010_0000_0000,
    S_ADMIT   = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    TGT_NONE  = 2'd0,
    TGT_SMALL = 2'd1,
    TGT_MAIN  = 2'd2
  } tgt_e;

  state_e state_q, state_d;

  // configuration
  logic [CW-1:0]                   scap_q, mcap_q, gcap_q;
  logic [s3fcr_pkg::THR_W-1:0]     thr_q;

  // access context
  logic [KEY_BITS-1:0]             key_q, key_d;
  logic [SZ_W-1:0]                 size_q, size_d;
  logic                            hit_q, hit_d, gh_q, gh_d, ret_q, ret_d;
  tgt_e                            tgt_q, tgt_d, adm_q, adm_d;
  logic [s3fcr_pkg::EV_W-1:0]      ev_q, ev_d;
  logic [ENT_W-1:0]                hold_q, hold_d;
  logic [SU_W-1:0]                 sused_q, sused_d;
  logic [MU_W-1:0]                 mused_q, mused_d;
  logic [GU_W-1:0]                 gused_q, gused_d;

  // result register
  logic                            m_valid_q, m_valid_d;
  logic [s3fcr_pkg::M_DATA_W-1:0]  m_data_q, m_data_d;

  // queue ports
  s3fcr_pkg::chain_ctl_t           s_ctl, m_ctl, g_ctl;
  logic [ENT_W-1:0]                s_push, m_push, g_push;
  logic [ENT_W-1:0]                s_head, m_head, g_head;
  logic [SC_W-1:0]                 s_cnt;
  logic [MC_W-1:0]                 m_cnt;
  logic [GC_W-1:0]                 g_cnt;
  logic                            s_hit, m_hit, g_hit;
  logic [SZ_W-1:0]                 s_hsz, m_hsz, g_hsz;
  logic                            s_hole, m_hole, g_hole;
  logic [KEY_BITS-1:0]             g_key;

  logic [CW:0]                     total;
  logic                            need, small_full, main_full, ghost_full;
  logic [SZ_W-1:0]                 hold_size;
  logic [KEY_BITS-1:0]             hold_key;
  logic [s3fcr_pkg::EV_W-1:0]      ev_inc;

  assign total      = {1'b0, scap_q} + {1'b0, mcap_q};
  assign small_full = (s_cnt >= SC_W'(SMALL_SLOTS));
  assign main_full  = (m_cnt >= MC_W'(MAIN_SLOTS));
  assign ghost_full = (g_cnt >= GC_W'(GHOST_SLOTS));
  assign hold_size  = hold_q[FW +: SZ_W];
  assign hold_key   = hold_q[ENT_W-1 -: KEY_BITS];
  assign ev_inc     = (ev_q == '1) ? ev_q : ev_q + 1'b1;
  assign g_key      = (state_q == S_LOOK) ? key_q : hold_key;

  assign need = (CMP_W'(sused_q) + CMP_W'(mused_q) + CMP_W'(size_q) > CMP_W'(total)) ||
                (tgt_q == TGT_SMALL && small_full) || (tgt_q == TGT_MAIN && main_full);

  // configuration writes are always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scap_q <= s3fcr_pkg::SMALL_CAP_RST;
      mcap_q <= s3fcr_pkg::MAIN_CAP_RST;
      gcap_q <= s3fcr_pkg::GHOST_CAP_RST;
      thr_q  <= s3fcr_pkg::THR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        s3fcr_pkg::REG_SMALL_CAP: scap_q <= cfg_data_i;
        s3fcr_pkg::REG_MAIN_CAP:  mcap_q <= cfg_data_i;
        s3fcr_pkg::REG_GHOST_CAP: gcap_q <= cfg_data_i;
        s3fcr_pkg::REG_THRESHOLD: thr_q  <= cfg_data_i[s3fcr_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    size_d    = size_q;
    hit_d     = hit_q;
    gh_d      = gh_q;
    ret_d     = ret_q;
    tgt_d     = tgt_q;
    adm_d     = adm_q;
    ev_d      = ev_q;
    hold_d    = hold_q;
    sused_d   = sused_q;
    mused_d   = mused_q;
    gused_d   = gused_q;
    m_valid_d = m_valid_q & ~m_tready_i;
    m_data_d  = m_data_q;
    s_ctl     = '{op: s3fcr_pkg::OP_NONE, cmp_en: 1'b0};
    m_ctl     = '{op: s3fcr_pkg::OP_NONE, cmp_en: 1'b0};
    g_ctl     = '{op: s3fcr_pkg::OP_NONE, cmp_en: 1'b0};
    s_push    = {key_q, size_q, {FW{1'b0}}};
    m_push    = {key_q, size_q, {FW{1'b0}}};
    g_push    = {hold_key, hold_size, {FW{1'b0}}};
    s_tready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          key_d   = KEY_BITS'(s_tdata_i[s3fcr_pkg::IN_KEY_W-1:0]);
          size_d  = s_tdata_i[s3fcr_pkg::IN_KEY_W +: SZ_W];
          hit_d   = 1'b0;
          gh_d    = 1'b0;
          tgt_d   = TGT_NONE;
          adm_d   = TGT_NONE;
          ev_d    = '0;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        // bump in small; otherwise drop from ghost and bump in main
        s_ctl = '{op: s3fcr_pkg::OP_BUMP, cmp_en: 1'b1};
        m_ctl = '{op: s_hit ? s3fcr_pkg::OP_NONE : s3fcr_pkg::OP_BUMP, cmp_en: 1'b1};
        g_ctl = '{op: (!s_hit && gcap_q != '0) ? s3fcr_pkg::OP_REMOVE : s3fcr_pkg::OP_NONE,
                  cmp_en: 1'b1};
        hit_d = s_hit | m_hit;
        gh_d  = !s_hit && (gcap_q != '0) && g_hit;
        if (!s_hit && (gcap_q != '0) && g_hit) begin
          gused_d = gused_q - GU_W'(g_hsz);
          state_d = S_COMPACT;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_COMPACT: begin
        g_ctl = '{op: s3fcr_pkg::OP_COMPACT, cmp_en: 1'b0};
        if (!g_hole) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!hit_q && ({1'b0, 8'd0, size_q} <= {1'b0, scap_q}) &&
            ({9'd0, size_q} <= total)) begin
          if (gh_q) begin
            tgt_d = TGT_MAIN;
          end else if ({8'd0, size_q} < scap_q) begin
            tgt_d = TGT_SMALL;
          end else begin
            tgt_d = TGT_NONE;
          end
          state_d = S_EVLOOP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_EVLOOP: begin
        if (!need || (s_cnt == '0 && m_cnt == '0)) begin
          state_d = S_ADMIT;
        end else if ((CMP_W'(mused_q) > CMP_W'(mcap_q)) || main_full || s_cnt == '0) begin
          ret_d   = 1'b0;
          state_d = S_EVMAIN;
        end else begin
          state_d = S_EVSMALL;
        end
      end
      S_EVMAIN: begin
        if (m_cnt == '0) begin
          state_d = ret_q ? S_PROMOTE : S_EVLOOP;
        end else if (m_head[FW-1:0] != '0) begin
          m_ctl = '{op: s3fcr_pkg::OP_ROTATE, cmp_en: 1'b0};
        end else begin
          m_ctl   = '{op: s3fcr_pkg::OP_POP, cmp_en: 1'b0};
          mused_d = mused_q - MU_W'(m_head[FW +: SZ_W]);
          ev_d    = ev_inc;
          state_d = ret_q ? S_PROMOTE : S_EVLOOP;
        end
      end
      S_EVSMALL: begin
        if (s_cnt == '0) begin
          state_d = S_EVLOOP;
        end else begin
          s_ctl   = '{op: s3fcr_pkg::OP_POP, cmp_en: 1'b0};
          sused_d = sused_q - SU_W'(s_head[FW +: SZ_W]);
          hold_d  = s_head;
          if ({1'b0, s_head[FW-1:0]} >= thr_q) begin
            if (main_full) begin
              ret_d   = 1'b1;
              state_d = S_EVMAIN;
            end else begin
              state_d = S_PROMOTE;
            end
          end else begin
            ev_d    = ev_inc;
            state_d = S_GPUT;
          end
        end
      end
      S_PROMOTE: begin
        m_push = {hold_key, hold_size, {FW{1'b0}}};
        if (!main_full) begin
          m_ctl   = '{op: s3fcr_pkg::OP_PUSH, cmp_en: 1'b0};
          mused_d = mused_q + MU_W'(hold_size);
        end
        state_d = S_EVSMALL;
      end
      S_GPUT: begin
        g_ctl = '{op: s3fcr_pkg::OP_NONE, cmp_en: 1'b1};
        if (gcap_q == '0 || g_hit || ({8'd0, hold_size} > gcap_q)) begin
          state_d = S_EVLOOP;
        end else begin
          state_d = S_GEVICT;
        end
      end
      S_GEVICT: begin
        // drop oldest ghost keys until the held key fits
        if (g_cnt != '0 &&
            ((GCM_W'(gused_q) + GCM_W'(hold_size) > GCM_W'(gcap_q)) || ghost_full)) begin
          g_ctl   = '{op: s3fcr_pkg::OP_POP, cmp_en: 1'b0};
          gused_d = gused_q - GU_W'(g_head[FW +: SZ_W]);
        end else begin
          g_ctl   = '{op: s3fcr_pkg::OP_PUSH, cmp_en: 1'b0};
          gused_d = gused_q + GU_W'(hold_size);
          state_d = S_EVLOOP;
        end
      end
      S_ADMIT: begin
        if (tgt_q == TGT_MAIN && !main_full) begin
          m_ctl   = '{op: s3fcr_pkg::OP_PUSH, cmp_en: 1'b0};
          mused_d = mused_q + MU_W'(size_q);
          adm_d   = TGT_MAIN;
        end else if (tgt_q == TGT_SMALL && !small_full) begin
          s_ctl   = '{op: s3fcr_pkg::OP_PUSH, cmp_en: 1'b0};
          sused_d = sused_q + SU_W'(size_q);
          adm_d   = TGT_SMALL;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!m_valid_q || m_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'd0, ev_q, adm_q, gh_q, hit_q};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sused_q   <= '0;
      mused_q   <= '0;
      gused_q   <= '0;
      m_valid_q <= 1'b0;
      ret_q     <= 1'b0;
      tgt_q     <= TGT_NONE;
    end else begin
      state_q   <= state_d;
      sused_q   <= sused_d;
      mused_q   <= mused_d;
      gused_q   <= gused_d;
      m_valid_q <= m_valid_d;
      ret_q     <= ret_d;
      tgt_q     <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    size_q   <= size_d;
    hit_q    <= hit_d;
    gh_q     <= gh_d;
    adm_q    <= adm_d;
    ev_q     <= ev_d;
    hold_q   <= hold_d;
    m_data_q <= m_data_d;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  s3fcr_chain #(.SLOTS(SMALL_SLOTS), .KEY_W(KEY_BITS)) u_small (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (s_ctl),
    .cmp_key_i (key_q),
    .push_ent_i(s_push),
    .head_ent_o(s_head),
    .count_o   (s_cnt),
    .hit_o     (s_hit),
    .hit_size_o(s_hsz),
    .hole_o    (s_hole)
  );

  s3fcr_chain #(.SLOTS(MAIN_SLOTS), .KEY_W(KEY_BITS)) u_main (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (m_ctl),
    .cmp_key_i (key_q),
    .push_ent_i(m_push),
    .head_ent_o(m_head),
    .count_o   (m_cnt),
    .hit_o     (m_hit),
    .hit_size_o(m_hsz),
    .hole_o    (m_hole)
  );

  s3fcr_chain #(.SLOTS(GHOST_SLOTS), .KEY_W(KEY_BITS)) u_ghost (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (g_ctl),
    .cmp_key_i (g_key),
    .push_ent_i(g_push),
    .head_ent_o(g_head),
    .count_o   (g_cnt),
    .hit_o     (g_hit),
    .hit_size_o(g_hsz),
    .hole_o    (g_hole)
  );

  // small and main never hold holes; their hit sizes are not needed
  `S3FCR_ASSERT_NOW(a_no_queue_holes, state_q != S_IDLE, !s_hole && !m_hole && (s_hsz == s_hsz) && (m_hsz == m_hsz), "hole in small or main queue")
  `S3FCR_ASSERT_NEXT(a_one_access, s_tvalid_i && s_tready_o, !s_tready_o, "second access taken while busy")
  `S3FCR_ASSERT_NOW(a_small_room, state_q == S_ADMIT && tgt_q == TGT_SMALL, !small_full, "small queue full at admission")
  `S3FCR_ASSERT_NOW(a_main_room, state_q == S_ADMIT && tgt_q == TGT_MAIN, !main_full, "main queue full at admission")

endmodule

`default_nettype wire
